### hdl/csalu_pkg.sv
package csalu_pkg;

    // Operation codes carried on the request.
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // Status codes returned with each result.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_DIV_ZERO = 2'd2
    } t_status;

    localparam int unsigned DataW    = 32;
    localparam int unsigned WideW    = 2 * DataW;
    localparam int unsigned DivSteps = DataW;

    // Payload that travels down the pipeline with each request.
    typedef struct packed {
        t_op                      op;
        logic signed [WideW-1:0]  exact;     // exact add, subtract or multiply result
        logic        [DataW-1:0]  rem;       // partial remainder of the divider
        logic        [DataW-1:0]  dq;        // dividend bits shifting out, quotient in
        logic        [DataW-1:0]  dvsr;      // divisor magnitude
        logic                     neg_q;     // quotient is negative
        logic                     div_zero;  // divisor was zero
    } t_stage;

endpackage

### hdl/csalu_prep.sv
module csalu_prep import csalu_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  logic [1:0]              i_req_type,
    input  logic signed [DataW-1:0] i_operand_a,
    input  logic signed [DataW-1:0] i_operand_b,
    output logic                    o_valid,
    output t_stage                  o_data
);

    logic                    r_valid;
    t_stage                  r_data;
    t_stage                  n_data;
    t_op                     op;
    logic signed [WideW-1:0] prod;
    logic signed [WideW-1:0] wide_a;
    logic signed [WideW-1:0] wide_b;

    assign op     = t_op'(i_req_type);
    assign wide_a = WideW'(i_operand_a);
    assign wide_b = WideW'(i_operand_b);
    assign prod   = i_operand_a * i_operand_b;

    always_comb begin
        n_data          = '0;
        n_data.op       = op;
        n_data.neg_q    = i_operand_a[DataW-1] ^ i_operand_b[DataW-1];
        n_data.div_zero = (i_operand_b == '0);
        n_data.rem      = '0;
        // The magnitude of the most negative value still fits as unsigned.
        n_data.dq       = i_operand_a[DataW-1] ? (DataW'(0) - DataW'(i_operand_a))
                                               : DataW'(i_operand_a);
        n_data.dvsr     = i_operand_b[DataW-1] ? (DataW'(0) - DataW'(i_operand_b))
                                               : DataW'(i_operand_b);
        case (op)
            OP_ADD:  n_data.exact = wide_a + wide_b;
            OP_SUB:  n_data.exact = wide_a - wide_b;
            OP_MUL:  n_data.exact = prod;
            default: n_data.exact = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### hdl/csalu_div_stage.sv
module csalu_div_stage import csalu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  logic   i_valid,
    input  t_stage i_data,
    output logic   o_valid,
    output t_stage o_data
);

    logic             r_valid;
    t_stage           r_data;
    t_stage           n_data;
    logic [DataW:0]   shifted;
    logic [DataW:0]   diff;
    logic             take;

    // One restoring step: bring down the next dividend bit and subtract
    // the divisor when it fits.
    assign shifted = {i_data.rem, i_data.dq[DataW-1]};
    assign diff    = shifted - {1'b0, i_data.dvsr};
    assign take    = (shifted >= {1'b0, i_data.dvsr});

    always_comb begin
        n_data     = i_data;
        n_data.rem = take ? diff[DataW-1:0] : shifted[DataW-1:0];
        n_data.dq  = {i_data.dq[DataW-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### hdl/csalu_final.sv
module csalu_final import csalu_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  t_stage                  i_data,
    output logic                    o_valid,
    output logic signed [DataW-1:0] o_result_value,
    output logic [1:0]              o_status
);

    logic                    r_valid;
    logic signed [DataW-1:0] r_result;
    t_status                 r_status;
    logic signed [DataW-1:0] n_result;
    t_status                 n_status;
    logic                    wide_fits;

    // The exact result fits when all bits from the sign bit upwards agree.
    assign wide_fits = (i_data.exact[WideW-1:DataW-1] == '0) ||
                       (i_data.exact[WideW-1:DataW-1] == '1);

    always_comb begin
        n_result = '0;
        n_status = ST_OK;
        if (i_data.op == OP_DIV) begin
            if (i_data.div_zero) begin
                n_status = ST_DIV_ZERO;
            end else if (!i_data.neg_q && i_data.dq[DataW-1]) begin
                // Only the most negative value over minus one lands here.
                n_status = ST_OVERFLOW;
            end else begin
                n_result = i_data.neg_q ? (DataW'(0) - i_data.dq) : i_data.dq;
            end
        end else begin
            if (wide_fits) begin
                n_result = i_data.exact[DataW-1:0];
            end else begin
                n_status = ST_OVERFLOW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_result <= n_result;
            r_status <= n_status;
        end
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_result;
    assign o_status       = r_status;

endmodule

### hdl/checked_signed_int32_alu.sv
// Accepted requests pass the prep stage, the 32-stage radix-2 divider pipeline
// and the final stage. Throughput: one request per cycle while o_stall is low.
// Every operation travels the same pipeline, so results leave in request order.
// Reset (i_rst_n, synchronous, active low) clears every stage valid bit; data
// registers are not reset.
module checked_signed_int32_alu import csalu_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_req_type,
    input  logic signed [DataW-1:0] i_operand_a,
    input  logic signed [DataW-1:0] i_operand_b,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [DataW-1:0] o_result_value,
    output logic [1:0]              o_status
);

    // The pipeline moves as one: it advances unless a finished result sits
    // in the output register and the consumer is stalling it. Bubbles move
    // along freely, so a new request is taken in every cycle that the
    // output is free or being taken.
    logic   adv;
    logic   stage_valid [DivSteps+1];
    t_stage stage_data  [DivSteps+1];

    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // First stage: operand magnitudes for the divider, and the exact
    // 64-bit sum, difference or product.
    csalu_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_valid     (i_valid),
        .i_req_type  (i_req_type),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (stage_valid[0]),
        .o_data      (stage_data[0])
    );

    // Divider: one quotient bit per stage. Requests that are not divides
    // pass through these stages with their exact result untouched.
    for (genvar g = 0; g < DivSteps; g++) begin : g_div
        csalu_div_stage u_div_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (stage_valid[g]),
            .i_data  (stage_data[g]),
            .o_valid (stage_valid[g+1]),
            .o_data  (stage_data[g+1])
        );
    end

    // Last stage: quotient sign, range check against the signed 32-bit
    // range, error status, and the output register.
    csalu_final u_final (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_valid        (stage_valid[DivSteps]),
        .i_data         (stage_data[DivSteps]),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

endmodule

### tb/alu_result_checker.sv
`timescale 1ns / 1ps

module alu_result_checker import csalu_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_req_valid,
    input  logic                    i_req_stall,
    input  logic [1:0]              i_req_type,
    input  logic signed [DataW-1:0] i_operand_a,
    input  logic signed [DataW-1:0] i_operand_b,
    input  logic                    i_res_valid,
    input  logic                    i_res_stall,
    input  logic signed [DataW-1:0] i_result_value,
    input  logic [1:0]              i_status,
    output int                      o_pending,
    output int                      o_fail_count
);

    typedef struct {
        logic signed [DataW-1:0] value;
        t_status                 status;
    } t_alu_outcome;

    localparam longint Int32Max = (longint'(1) <<< 31) - 1;
    localparam longint Int32Min = -(longint'(1) <<< 31);

    t_alu_outcome awaited_results[$];
    int           mismatch_count = 0;

    // Exact arithmetic at 64 bits, then a range check against int32.
    function automatic t_alu_outcome predict_alu_result(t_op op, logic signed [DataW-1:0] a,
                                                        logic signed [DataW-1:0] b);
        longint       wide_a;
        longint       wide_b;
        longint       exact;
        t_alu_outcome outcome;
        wide_a         = a;
        wide_b         = b;
        exact          = 0;
        outcome.status = ST_OK;
        case (op)
            OP_ADD: exact = wide_a + wide_b;
            OP_SUB: exact = wide_a - wide_b;
            OP_MUL: exact = wide_a * wide_b;
            OP_DIV: begin
                // A zero divisor wins over any overflow check.
                if (wide_b == 0) outcome.status = ST_DIV_ZERO;
                else exact = wide_a / wide_b;
            end
            default: exact = 0;
        endcase
        if (outcome.status == ST_OK && (exact > Int32Max || exact < Int32Min))
            outcome.status = ST_OVERFLOW;
        outcome.value = (outcome.status == ST_OK) ? exact[DataW-1:0] : '0;
        return outcome;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_alu_outcome oldest;
        if (!i_rst_n) begin
            o_pending    <= 0;
            o_fail_count <= mismatch_count;
        end else begin
            // The result is checked before the new request is queued, so a result
            // can never be matched against a request accepted on the same edge.
            if (i_res_valid && !i_res_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: result_value %0d status %0d",
                           i_result_value, i_status);
                    mismatch_count++;
                end else begin
                    oldest = awaited_results.pop_front();
                    if (i_result_value !== oldest.value) begin
                        $error("result_value mismatch: expected %0d, actual %0d",
                               oldest.value, i_result_value);
                        mismatch_count++;
                    end
                    if (i_status !== oldest.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               oldest.status, i_status);
                        mismatch_count++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall)
                awaited_results.push_back(predict_alu_result(t_op'(i_req_type),
                                                             i_operand_a, i_operand_b));
            o_pending    <= awaited_results.size();
            o_fail_count <= mismatch_count;
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the checked int32 ALU. The checker instantiated beside
// the block watches both channels, predicts every result and counts failures; this
// module only produces requests, drives the result-side stall and ends the run.
module tb import csalu_pkg::*; ();

    localparam int RandomRequests = 450;
    // The drain window and the watchdog are sized well beyond the block's
    // latency plus the longest receiver stall.
    localparam int DrainCycles    = 100;
    localparam int IdleLimit      = 2000;

    localparam logic signed [DataW-1:0] Int32Max = 32'sh7FFF_FFFF;
    localparam logic signed [DataW-1:0] Int32Min = 32'sh8000_0000;
    localparam logic signed [DataW-1:0] MinusOne = -32'sd1;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_valid        = 1'b0;
    logic [1:0]              i_req_type     = 2'd0;
    logic signed [DataW-1:0] i_operand_a    = '0;
    logic signed [DataW-1:0] i_operand_b    = '0;
    logic                    i_stall        = 1'b0;
    logic                    o_stall;
    logic                    o_valid;
    logic signed [DataW-1:0] o_result_value;
    logic [1:0]              o_status;

    int pending_results;
    int fail_count;
    int idle_cycles = 0;

    // Receiver stall pattern: stretches of random length, each with its own
    // behaviour (never stalling, stalling lightly or stalling heavily).
    int stall_mode  = 0;
    int stall_left  = 0;

    always #2 i_clk = ~i_clk;

    checked_signed_int32_alu u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    alu_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_stall    (o_stall),
        .i_req_type     (i_req_type),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_result_value (o_result_value),
        .i_status       (o_status),
        .o_pending      (pending_results),
        .o_fail_count   (fail_count)
    );

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 99) < 30);
            default: i_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    // Watchdog: the run is abandoned when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one request and returns at the edge that accepts it. Valid stays
    // high on return, so back-to-back requests never drop it in between.
    task automatic send_request(t_op op, logic signed [DataW-1:0] a,
                                logic signed [DataW-1:0] b);
        i_valid     <= 1'b1;
        i_req_type  <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Operands are drawn from several families so that the range edges, small
    // values and products near the int32 boundary all turn up often.
    function automatic logic signed [DataW-1:0] pick_operand();
        logic signed [DataW-1:0] magnitude;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4:          return $signed($urandom_range(0, 64)) - 32;
            5: begin
                case ($urandom_range(0, 6))
                    0:       return Int32Min;
                    1:       return Int32Max;
                    2:       return '0;
                    3:       return 32'sd1;
                    4:       return MinusOne;
                    5:       return Int32Min + 1;
                    default: return Int32Max - 1;
                endcase
            end
            6, 7: begin
                magnitude = $urandom_range(1 << 15, 1 << 17);
                return $urandom_range(0, 1) ? -magnitude : magnitude;
            end
            default: begin
                magnitude = $urandom >> $urandom_range(0, 31);
                return $urandom_range(0, 1) ? -magnitude : magnitude;
            end
        endcase
    endfunction

    task automatic send_random_request();
        t_op                     op;
        logic signed [DataW-1:0] divisor;
        op      = t_op'($urandom_range(0, 3));
        divisor = pick_operand();
        // Zero divisors are made more frequent than chance alone would make them.
        if (op == OP_DIV && $urandom_range(0, 7) == 0) divisor = '0;
        send_request(op, pick_operand(), divisor);
    endtask

    initial begin : stimulus
        int  sent;
        int  burst;
        int  gap;
        bit  paused;
        sent   = 0;
        paused = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests: range edges of every operation, overflow in both
        // directions, the most negative value over minus one, division by zero
        // (including zero over zero) and truncation toward zero.
        send_request(OP_ADD, Int32Max, 32'sd1);
        send_request(OP_ADD, Int32Min, MinusOne);
        send_request(OP_ADD, Int32Max, Int32Min);
        send_request(OP_ADD, '0, '0);
        send_request(OP_ADD, Int32Max, '0);
        send_request(OP_SUB, Int32Min, 32'sd1);
        send_request(OP_SUB, Int32Max, MinusOne);
        send_request(OP_SUB, '0, Int32Min);
        send_request(OP_SUB, MinusOne, Int32Max);
        send_request(OP_SUB, Int32Min, Int32Min);
        send_request(OP_MUL, Int32Min, MinusOne);
        send_request(OP_MUL, Int32Min, 32'sd1);
        send_request(OP_MUL, Int32Max, Int32Max);
        send_request(OP_MUL, MinusOne, MinusOne);
        send_request(OP_MUL, 32'sd65536, 32'sd32768);
        send_request(OP_MUL, -32'sd65536, 32'sd32768);
        send_request(OP_MUL, Int32Min, Int32Min);
        send_request(OP_DIV, 32'sd5, '0);
        send_request(OP_DIV, '0, '0);
        send_request(OP_DIV, Int32Min, MinusOne);
        send_request(OP_DIV, Int32Min, 32'sd1);
        send_request(OP_DIV, 32'sd7, -32'sd2);
        send_request(OP_DIV, -32'sd7, 32'sd2);
        send_request(OP_DIV, Int32Max, Int32Min);
        send_request(OP_DIV, Int32Min, Int32Max);

        // Random requests in bursts. A gap of zero joins two bursts, which gives
        // long stretches in which the sender never idles.
        while (sent < RandomRequests) begin
            // Halfway through, the sender holds off until the block has returned
            // every outstanding result, so the pipeline runs completely empty once.
            if (!paused && sent >= RandomRequests / 2) begin
                paused  = 1'b1;
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_results != 0) @(posedge i_clk);
            end
            burst = $urandom_range(1, 16);
            for (int k = 0; k < burst && sent < RandomRequests; k++) begin
                send_random_request();
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        i_valid <= 1'b0;
        // One edge first, so the count already includes the last request.
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
